@@ src/tsls_pkg.sv @@
// Package: shared constants, codes and types of the scrollback line store.
package tsls_pkg;

  localparam int RING_LINES = 64;
  localparam int LINE_WIDTH = 128;
  localparam int SLOT_W     = $clog2(RING_LINES);
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int CNT_W      = 7;
  localparam int LEN_W      = 8;

  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_MIN = 8'h20;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TAB  = 3'b010,
    S_READ = 3'b100
  } state_e;

  typedef struct packed {
    logic              char_we;
    logic [ADDR_W-1:0] char_waddr;
    logic [7:0]        char_wdata;
    logic [ADDR_W-1:0] char_raddr;
    logic              len_we;
    logic [SLOT_W-1:0] len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic [SLOT_W-1:0] len_raddr;
  } mem_req_t;

endpackage

@@ src/tsls_store.sv @@
// Character store and line length table, synchronous (registered) read.
module tsls_store (
  input  logic                          clk_i,
  input  tsls_pkg::mem_req_t            req_i,
  output logic [7:0]                    char_rdata_o,
  output logic [tsls_pkg::LEN_W-1:0]    len_rdata_o
);

  logic [7:0]                 char_mem [tsls_pkg::RING_LINES * tsls_pkg::LINE_WIDTH];
  logic [tsls_pkg::LEN_W-1:0] len_mem  [tsls_pkg::RING_LINES];

  always_ff @(posedge clk_i) begin
    if (req_i.char_we) begin
      char_mem[req_i.char_waddr] <= req_i.char_wdata;
    end
    char_rdata_o <= char_mem[req_i.char_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.len_we) begin
      len_mem[req_i.len_waddr] <= req_i.len_wdata;
    end
    len_rdata_o <= len_mem[req_i.len_raddr];
  end

endmodule

@@ src/tsls_ctrl.sv @@
// Control: request decode, line ring bookkeeping, tab sequencing and results.
module tsls_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [tsls_pkg::SLOT_W-1:0]   line_index_i,
  input  logic [tsls_pkg::COL_W-1:0]    column_i,
  input  logic                          line_limit_we_i,
  input  logic [tsls_pkg::CNT_W-1:0]    line_limit_i,
  output tsls_pkg::mem_req_t            mem_req_o,
  input  logic [7:0]                    char_rdata_i,
  input  logic [tsls_pkg::LEN_W-1:0]    len_rdata_i,
  output logic                          result_strobe_o,
  output logic [7:0]                    read_char_o,
  output logic [tsls_pkg::LEN_W-1:0]    line_length_o,
  output logic [tsls_pkg::CNT_W-1:0]    line_count_o,
  output logic [1:0]                    status_o
);

  localparam logic [tsls_pkg::LEN_W-1:0] FULL_LEN = tsls_pkg::LEN_W'(tsls_pkg::LINE_WIDTH);
  localparam logic [tsls_pkg::CNT_W-1:0] MAX_CNT  = tsls_pkg::CNT_W'(tsls_pkg::RING_LINES);

  tsls_pkg::state_e state_q, state_d;

  logic [tsls_pkg::CNT_W-1:0]  limit_q, limit_d;
  logic [tsls_pkg::SLOT_W-1:0] oldest_q, oldest_d;
  logic [tsls_pkg::CNT_W-1:0]  held_q, held_d;
  logic                        cr_q, cr_d;
  logic [tsls_pkg::LEN_W-1:0]  cur_len_q, cur_len_d;
  logic [tsls_pkg::LEN_W-1:0]  tab_pos_q, tab_pos_d;
  logic [1:0]                  tab_cnt_q, tab_cnt_d;
  logic                        rd_bad_q, rd_bad_d;
  logic                        rd_cur_q, rd_cur_d;
  logic [tsls_pkg::COL_W-1:0]  rd_col_q, rd_col_d;

  logic                        strobe_q, strobe_d;
  logic [7:0]                  out_char_q, out_char_d;
  logic [tsls_pkg::LEN_W-1:0]  out_len_q, out_len_d;
  logic [tsls_pkg::CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [1:0]                  out_st_q, out_st_d;

  logic [tsls_pkg::SLOT_W-1:0] cur_slot, rd_slot;
  logic [tsls_pkg::CNT_W-1:0]  eff_limit;
  logic [tsls_pkg::CNT_W:0]    held_inc;
  logic [tsls_pkg::LEN_W-1:0]  base_len, tab_sum, rd_len;
  logic [tsls_pkg::CNT_W-1:0]  idx_ext;
  logic                        accept, dropped;

  assign cur_slot = oldest_q + held_q[tsls_pkg::SLOT_W-1:0] - tsls_pkg::SLOT_W'(1);
  assign rd_slot  = oldest_q + line_index_i;
  assign held_inc = {1'b0, held_q} + (tsls_pkg::CNT_W+1)'(1);
  assign base_len = cr_q ? '0 : cur_len_q;
  assign tab_sum  = base_len + tsls_pkg::LEN_W'(4);
  assign idx_ext  = tsls_pkg::CNT_W'(line_index_i);
  assign accept   = start && (state_q == tsls_pkg::S_IDLE);
  assign busy     = (state_q != tsls_pkg::S_IDLE);

  always_comb begin
    if (limit_q == '0) begin
      eff_limit = tsls_pkg::CNT_W'(1);
    end else if (limit_q > MAX_CNT) begin
      eff_limit = MAX_CNT;
    end else begin
      eff_limit = limit_q;
    end
  end

  always_comb begin
    if (rd_bad_q) begin
      rd_len = '0;
    end else if (rd_cur_q) begin
      rd_len = cur_len_q;
    end else begin
      rd_len = len_rdata_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    limit_d    = line_limit_we_i ? line_limit_i : limit_q;
    oldest_d   = oldest_q;
    held_d     = held_q;
    cr_d       = cr_q;
    cur_len_d  = cur_len_q;
    tab_pos_d  = tab_pos_q;
    tab_cnt_d  = tab_cnt_q;
    rd_bad_d   = rd_bad_q;
    rd_cur_d   = rd_cur_q;
    rd_col_d   = rd_col_q;
    strobe_d   = 1'b0;
    out_char_d = out_char_q;
    out_len_d  = out_len_q;
    out_cnt_d  = out_cnt_q;
    out_st_d   = out_st_q;
    dropped    = 1'b0;

    mem_req_o            = '0;
    mem_req_o.char_raddr = {rd_slot, column_i};
    mem_req_o.len_raddr  = rd_slot;
    mem_req_o.char_waddr = {cur_slot, base_len[tsls_pkg::COL_W-1:0]};
    mem_req_o.char_wdata = data_byte_i;
    mem_req_o.len_waddr  = cur_slot;
    mem_req_o.len_wdata  = cur_len_q;

    case (state_q)
      tsls_pkg::S_IDLE: begin
        if (accept && (req_type_i == tsls_pkg::REQ_READ)) begin
          rd_bad_d = (idx_ext >= held_q);
          rd_cur_d = (idx_ext == held_q - tsls_pkg::CNT_W'(1));
          rd_col_d = column_i;
          state_d  = tsls_pkg::S_READ;
        end else if (accept) begin
          cr_d = 1'b0;
          case (data_byte_i)
            tsls_pkg::CH_LF: begin
              mem_req_o.len_we = 1'b1;
              cur_len_d        = '0;
              if (held_inc > {1'b0, eff_limit}) begin
                oldest_d = oldest_q + tsls_pkg::SLOT_W'(1);
              end else begin
                held_d = held_inc[tsls_pkg::CNT_W-1:0];
              end
            end
            tsls_pkg::CH_CR: begin
              cr_d      = 1'b1;
              cur_len_d = base_len;
            end
            tsls_pkg::CH_TAB: begin
              mem_req_o.char_we    = !base_len[tsls_pkg::LEN_W-1];
              mem_req_o.char_wdata = tsls_pkg::CH_SPACE;
              if (tab_sum > FULL_LEN) begin
                cur_len_d = FULL_LEN;
                dropped   = 1'b1;
              end else begin
                cur_len_d = tab_sum;
              end
              tab_pos_d = base_len + tsls_pkg::LEN_W'(1);
              tab_cnt_d = 2'd2;
              state_d   = tsls_pkg::S_TAB;
            end
            tsls_pkg::CH_BS: begin
              cur_len_d = (base_len != '0) ? base_len - tsls_pkg::LEN_W'(1) : '0;
            end
            default: begin
              if (data_byte_i >= tsls_pkg::CH_PRINT_MIN) begin
                if (base_len[tsls_pkg::LEN_W-1]) begin
                  cur_len_d = base_len;
                  dropped   = 1'b1;
                end else begin
                  mem_req_o.char_we = 1'b1;
                  cur_len_d         = base_len + tsls_pkg::LEN_W'(1);
                end
              end else begin
                cur_len_d = base_len;
              end
            end
          endcase
          strobe_d   = 1'b1;
          out_char_d = '0;
          out_len_d  = cur_len_d;
          out_cnt_d  = held_d;
          out_st_d   = dropped ? tsls_pkg::ST_DROP : tsls_pkg::ST_OK;
        end
      end
      tsls_pkg::S_TAB: begin
        mem_req_o.char_we    = !tab_pos_q[tsls_pkg::LEN_W-1];
        mem_req_o.char_waddr = {cur_slot, tab_pos_q[tsls_pkg::COL_W-1:0]};
        mem_req_o.char_wdata = tsls_pkg::CH_SPACE;
        tab_pos_d            = tab_pos_q + tsls_pkg::LEN_W'(1);
        tab_cnt_d            = tab_cnt_q - 2'd1;
        if (tab_cnt_q == 2'd0) begin
          state_d = tsls_pkg::S_IDLE;
        end
      end
      tsls_pkg::S_READ: begin
        strobe_d   = 1'b1;
        out_len_d  = rd_len;
        out_char_d = (!rd_bad_q && ({1'b0, rd_col_q} < rd_len)) ? char_rdata_i : '0;
        out_cnt_d  = held_q;
        out_st_d   = rd_bad_q ? tsls_pkg::ST_RANGE : tsls_pkg::ST_OK;
        state_d    = tsls_pkg::S_IDLE;
      end
      default: begin
        state_d = tsls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsls_pkg::S_IDLE;
      limit_q   <= MAX_CNT;
      oldest_q  <= '0;
      held_q    <= tsls_pkg::CNT_W'(1);
      cr_q      <= 1'b0;
      cur_len_q <= '0;
      tab_cnt_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      limit_q   <= limit_d;
      oldest_q  <= oldest_d;
      held_q    <= held_d;
      cr_q      <= cr_d;
      cur_len_q <= cur_len_d;
      tab_cnt_q <= tab_cnt_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tab_pos_q  <= tab_pos_d;
    rd_bad_q   <= rd_bad_d;
    rd_cur_q   <= rd_cur_d;
    rd_col_q   <= rd_col_d;
    out_char_q <= out_char_d;
    out_len_q  <= out_len_d;
    out_cnt_q  <= out_cnt_d;
    out_st_q   <= out_st_d;
  end

  assign result_strobe_o = strobe_q;
  assign read_char_o     = out_char_q;
  assign line_length_o   = out_len_q;
  assign line_count_o    = out_cnt_q;
  assign status_o        = out_st_q;

endmodule

@@ src/terminal_scrollback_line_store.sv @@
// Top level: terminal scrollback line store.
//
// A request is transferred at a rising edge with start high and busy low.
// req_type_i selects an append of data_byte_i or a read of the character at
// line_index_i / column_i. Every request gives one result, shown for exactly
// one cycle with result_strobe_o high; the receiver cannot stall it.
// An append result appears the cycle after the transfer; a read result
// passes the registered memory read and then the result registers.
// An append other than a tab leaves busy low; a tab stores up to four
// spaces (one char store write port, one space per cycle), a read waits
// for the memory read. busy is high while a tab or read is still in progress.
// line_limit_we_i writes line_limit_i at any edge; write it only while idle.
// Reset brings one empty line, limit 64, no pending CR; no clearing pass is
// needed since every held line length is written before it is read.
module terminal_scrollback_line_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [tsls_pkg::SLOT_W-1:0]   line_index_i,
  input  logic [tsls_pkg::COL_W-1:0]    column_i,
  input  logic                          line_limit_we_i,
  input  logic [tsls_pkg::CNT_W-1:0]    line_limit_i,
  output logic                          result_strobe_o,
  output logic [7:0]                    read_char_o,
  output logic [tsls_pkg::LEN_W-1:0]    line_length_o,
  output logic [tsls_pkg::CNT_W-1:0]    line_count_o,
  output logic [1:0]                    status_o
);

  tsls_pkg::mem_req_t         mem_req;
  logic [7:0]                 char_rdata;
  logic [tsls_pkg::LEN_W-1:0] len_rdata;

  tsls_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .line_index_i    (line_index_i),
    .column_i        (column_i),
    .line_limit_we_i (line_limit_we_i),
    .line_limit_i    (line_limit_i),
    .mem_req_o       (mem_req),
    .char_rdata_i    (char_rdata),
    .len_rdata_i     (len_rdata),
    .result_strobe_o (result_strobe_o),
    .read_char_o     (read_char_o),
    .line_length_o   (line_length_o),
    .line_count_o    (line_count_o),
    .status_o        (status_o)
  );

  tsls_store u_store (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .char_rdata_o (char_rdata),
    .len_rdata_o  (len_rdata)
  );

endmodule
